// File: hw/rtl/rsls_pkg.sv
// ----------------------------------------------------------------------------
// rsls_pkg
// Shared constants, register codes and stage types for the radial spotlight
// luminance scaler.
// ----------------------------------------------------------------------------
package rsls_pkg;

	// Default field widths
	localparam int COORD_BITS_DEF = 12;
	localparam int LUMA_BITS_DEF  = 16;

	// Offset window: both offsets must stay within this to use the linear law
	localparam int          OFF_BITS   = 8;
	localparam logic [7:0]  MAX_OFFSET = 8'd160;

	// Squared distance limit (radius 160)
	localparam int          D2_BITS = 17;
	localparam logic [16:0] MAX_D2  = 17'd25600;

	// Square root unit geometry
	localparam int ROOT_BITS       = 16;
	localparam int RAD_BITS        = 16;
	localparam int REM_BITS        = 20;
	localparam int SQRT_STAGES     = 4;
	localparam int STEPS_PER_STAGE = ROOT_BITS / SQRT_STAGES;

	// Scale law: 1.0 - 0.005 * distance, in Q16
	localparam int          SCALE_BITS = 17;
	localparam logic [15:0] SLOPE_Q15  = 16'd41943;
	localparam logic [16:0] ONE_Q16    = 17'd65536;
	localparam logic [16:0] FAR_SCALE  = 17'd13107;

	// Configuration register indexes
	localparam int         CFG_INDEX_BITS = 8;
	localparam logic [7:0] CFG_CENTER_X   = 8'd0;
	localparam logic [7:0] CFG_CENTER_Y   = 8'd1;

	// Absolute offsets after the first stage
	typedef struct packed {
		logic                near;
		logic [OFF_BITS-1:0] ax;
		logic [OFF_BITS-1:0] ay;
	} offs_t;

	// Working state of the digit-by-digit square root
	typedef struct packed {
		logic                 far;
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
		logic [RAD_BITS-1:0]  rad;
	} sqrt_t;

endpackage

// File: hw/rtl/rsls_offset.sv
// ----------------------------------------------------------------------------
// rsls_offset
// First stage: signed offsets from the centre, magnitudes and window check.
// ----------------------------------------------------------------------------
module rsls_offset #(
	parameter int COORD_BITS = rsls_pkg::COORD_BITS_DEF,
	parameter int LUMA_BITS  = rsls_pkg::LUMA_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [COORD_BITS-1:0]        pixel_x,
	input  logic [COORD_BITS-1:0]        pixel_y,
	input  logic [LUMA_BITS-1:0]         luma_in,
	input  logic signed [COORD_BITS+1:0] center_x,
	input  logic signed [COORD_BITS+1:0] center_y,
	output rsls_pkg::offs_t              offs_s1,
	output logic [LUMA_BITS-1:0]         luma_s1
);

	localparam int DW = COORD_BITS + 3;

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic [DW-1:0]        ax;
	logic [DW-1:0]        ay;

	// Form signed offsets with one spare bit and take magnitudes
	assign dx = $signed({3'b000, pixel_x}) - $signed({center_x[COORD_BITS+1], center_x});
	assign dy = $signed({3'b000, pixel_y}) - $signed({center_y[COORD_BITS+1], center_y});
	assign ax = dx[DW-1] ? (~dx + 1'b1) : dx;
	assign ay = dy[DW-1] ? (~dy + 1'b1) : dy;

	// Register magnitudes; only the low bits matter inside the window
	always_ff @(posedge clk) begin
		if (en) begin
			offs_s1.near <= (ax <= DW'(rsls_pkg::MAX_OFFSET)) &&
			                (ay <= DW'(rsls_pkg::MAX_OFFSET));
			offs_s1.ax   <= ax[rsls_pkg::OFF_BITS-1:0];
			offs_s1.ay   <= ay[rsls_pkg::OFF_BITS-1:0];
			luma_s1      <= luma_in;
		end
	end

endmodule

// File: hw/rtl/rsls_dist.sv
// ----------------------------------------------------------------------------
// rsls_dist
// Second stage: squared distance, far test and seed of the square root.
// ----------------------------------------------------------------------------
module rsls_dist #(
	parameter int LUMA_BITS = rsls_pkg::LUMA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  rsls_pkg::offs_t      offs_s1,
	input  logic [LUMA_BITS-1:0] luma_s1,
	output rsls_pkg::sqrt_t      sq_s2,
	output logic [LUMA_BITS-1:0] luma_s2
);

	logic [2*rsls_pkg::OFF_BITS-1:0] sqx;
	logic [2*rsls_pkg::OFF_BITS-1:0] sqy;
	logic [rsls_pkg::D2_BITS-1:0]    d2;

	// Sum of squares
	assign sqx = offs_s1.ax * offs_s1.ax;
	assign sqy = offs_s1.ay * offs_s1.ay;
	assign d2  = {1'b0, sqx} + {1'b0, sqy};

	// Seed the root: radicand is d2 followed by sixteen zero bits
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2.far  <= !offs_s1.near || (d2 > rsls_pkg::MAX_D2);
			sq_s2.rem  <= '0;
			sq_s2.root <= '0;
			sq_s2.rad  <= d2[rsls_pkg::RAD_BITS-1:0];
			luma_s2    <= luma_s1;
		end
	end

endmodule

// File: hw/rtl/rsls_sqrt_stage.sv
// ----------------------------------------------------------------------------
// rsls_sqrt_stage
// One pipeline stage of the restoring square root, four root bits per stage.
// ----------------------------------------------------------------------------
module rsls_sqrt_stage #(
	parameter int LUMA_BITS = rsls_pkg::LUMA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  rsls_pkg::sqrt_t      sq_in,
	input  logic [LUMA_BITS-1:0] luma_in,
	output rsls_pkg::sqrt_t      sq_q,
	output logic [LUMA_BITS-1:0] luma_q
);

	rsls_pkg::sqrt_t nxt;

	// Bring down two radicand bits per step and try the next root bit
	always_comb begin
		logic [rsls_pkg::REM_BITS-1:0] trial;
		nxt = sq_in;
		for (int k = 0; k < rsls_pkg::STEPS_PER_STAGE; k++) begin
			nxt.rem = {nxt.rem[rsls_pkg::REM_BITS-3:0], nxt.rad[rsls_pkg::RAD_BITS-1 -: 2]};
			trial   = rsls_pkg::REM_BITS'({nxt.root, 2'b01});
			if (nxt.rem >= trial) begin
				nxt.rem  = nxt.rem - trial;
				nxt.root = {nxt.root[rsls_pkg::ROOT_BITS-2:0], 1'b1};
			end else begin
				nxt.root = {nxt.root[rsls_pkg::ROOT_BITS-2:0], 1'b0};
			end
			nxt.rad = {nxt.rad[rsls_pkg::RAD_BITS-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_q   <= nxt;
			luma_q <= luma_in;
		end
	end

endmodule

// File: hw/rtl/rsls_scale.sv
// ----------------------------------------------------------------------------
// rsls_scale
// Final two stages: scale from distance, then luminance times scale.
// ----------------------------------------------------------------------------
module rsls_scale #(
	parameter int LUMA_BITS = rsls_pkg::LUMA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en_scale,
	input  logic                 en_out,
	input  rsls_pkg::sqrt_t      sq_in,
	input  logic [LUMA_BITS-1:0] luma_in,
	output logic [LUMA_BITS-1:0] luma_out_s8
);

	logic [31:0]                     slope_prod;
	logic [rsls_pkg::SCALE_BITS-1:0] scale_s7;
	logic [LUMA_BITS-1:0]            luma_s7;
	logic [LUMA_BITS+16:0]           luma_prod;

	// Linear fall-off, or the floor value outside the radius
	assign slope_prod = sq_in.root * rsls_pkg::SLOPE_Q15;

	always_ff @(posedge clk) begin
		if (en_scale) begin
			scale_s7 <= sq_in.far ? rsls_pkg::FAR_SCALE
			                      : rsls_pkg::ONE_Q16 - slope_prod[31:15];
			luma_s7  <= luma_in;
		end
	end

	// Apply the scale in Q16
	assign luma_prod = luma_s7 * scale_s7;

	always_ff @(posedge clk) begin
		if (en_out) begin
			luma_out_s8 <= luma_prod[LUMA_BITS+15:16];
		end
	end

endmodule

// File: hw/rtl/radial_spotlight_luma_scale.sv
// Throughput: one pixel per cycle while the output is not stalled; the 16-bit
// square root is spread over four stages of four root bits each, and the two
// multiplies sit in stages of their own. Each stage holds only while the stage
// after it is full and stalled.
// Reset (arst_n low) empties the pipeline and sets both centre registers to 0.
// ----------------------------------------------------------------------------
// radial_spotlight_luma_scale
// Scales pixel luminance by a linear radial fall-off around a set centre.
// ----------------------------------------------------------------------------
module radial_spotlight_luma_scale #(
	parameter int COORD_BITS = rsls_pkg::COORD_BITS_DEF,
	parameter int LUMA_BITS  = rsls_pkg::LUMA_BITS_DEF,
	localparam int IN_W  = ((2*COORD_BITS + LUMA_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((LUMA_BITS + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata, low bit up: pixel_x, pixel_y, luma_in, zero fill
	input  logic [IN_W-1:0]                     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata, low bit up: luma_out, zero fill
	output logic [OUT_W-1:0]                    m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rsls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS+1:0]               cfg_data
);

	localparam int NST = 4 + rsls_pkg::SQRT_STAGES;

	logic signed [COORD_BITS+1:0] center_x_q;
	logic signed [COORD_BITS+1:0] center_y_q;
	logic [NST-1:0]               valid_q;
	logic [NST:0]                 rdy;

	rsls_pkg::offs_t              offs_s1;
	logic [LUMA_BITS-1:0]         luma_s1;
	rsls_pkg::sqrt_t              sq_s [rsls_pkg::SQRT_STAGES+1];
	logic [LUMA_BITS-1:0]         luma_sq [rsls_pkg::SQRT_STAGES+1];
	logic [LUMA_BITS-1:0]         luma_out_s8;

	// Configuration writes, always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rsls_pkg::CFG_CENTER_X: center_x_q <= cfg_data;
				rsls_pkg::CFG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Ready chain: a stage advances when empty or when the next one advances
	always_comb begin
		rdy[NST] = m_tready;
		for (int i = NST - 1; i >= 0; i--) begin
			rdy[i] = !valid_q[i] || rdy[i+1];
		end
	end

	assign s_tready = rdy[0];

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[0]) begin
				valid_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NST; i++) begin
				if (rdy[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	rsls_offset #(
		.COORD_BITS(COORD_BITS),
		.LUMA_BITS (LUMA_BITS)
	) u_offset (
		.clk     (clk),
		.en      (rdy[0]),
		.pixel_x (s_tdata[COORD_BITS-1:0]),
		.pixel_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.luma_in (s_tdata[2*COORD_BITS+LUMA_BITS-1:2*COORD_BITS]),
		.center_x(center_x_q),
		.center_y(center_y_q),
		.offs_s1 (offs_s1),
		.luma_s1 (luma_s1)
	);

	rsls_dist #(
		.LUMA_BITS(LUMA_BITS)
	) u_dist (
		.clk    (clk),
		.en     (rdy[1]),
		.offs_s1(offs_s1),
		.luma_s1(luma_s1),
		.sq_s2  (sq_s[0]),
		.luma_s2(luma_sq[0])
	);

	// Square root stages
	for (genvar g = 0; g < rsls_pkg::SQRT_STAGES; g++) begin : g_sqrt
		rsls_sqrt_stage #(
			.LUMA_BITS(LUMA_BITS)
		) u_stage (
			.clk    (clk),
			.en     (rdy[2+g]),
			.sq_in  (sq_s[g]),
			.luma_in(luma_sq[g]),
			.sq_q   (sq_s[g+1]),
			.luma_q (luma_sq[g+1])
		);
	end

	rsls_scale #(
		.LUMA_BITS(LUMA_BITS)
	) u_scale (
		.clk        (clk),
		.en_scale   (rdy[NST-2]),
		.en_out     (rdy[NST-1]),
		.sq_in      (sq_s[rsls_pkg::SQRT_STAGES]),
		.luma_in    (luma_sq[rsls_pkg::SQRT_STAGES]),
		.luma_out_s8(luma_out_s8)
	);

	assign m_tvalid = valid_q[NST-1];
	assign m_tdata  = OUT_W'(luma_out_s8);

	// Input back-pressure only ever comes from a stalled full output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

	// A full first stage that cannot advance keeps its request
	a_hold_first: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q[0] && !rdy[1]) |=> valid_q[0])
		else $error("first stage dropped a held request");

	// A write to the horizontal centre takes effect on the next cycle
	a_cfg_x: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && (cfg_index == rsls_pkg::CFG_CENTER_X)) |=>
		(center_x_q == $past(cfg_data)))
		else $error("centre x write lost");

	// A write to the vertical centre takes effect on the next cycle
	a_cfg_y: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && (cfg_index == rsls_pkg::CFG_CENTER_Y)) |=>
		(center_y_q == $past(cfg_data)))
		else $error("centre y write lost");

endmodule

// File: bench/radial_spotlight_luma_scale_tb.sv
// ----------------------------------------------------------------------------
// radial_spotlight_luma_scale_tb
// Self-checking bench for the radial spotlight luminance scaler. Pixel
// requests are queued by phase; most phases add random gaps. Each accepted
// request is predicted at once from a local copy of the centre registers, and
// every result is checked in order. The centre is moved between phases, and
// one phase holds the output off long enough to stall the input side.
// ----------------------------------------------------------------------------
module radial_spotlight_luma_scale_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Predictor constants: offset window, radius squared, far scale, slope
	localparam int              NEAR_LIMIT = 160;
	localparam int              RADIUS_SQ  = 25600;
	localparam longint unsigned DIM_SCALE  = 13107;
	localparam longint unsigned SLOPE      = 41943;
	localparam longint unsigned UNITY      = 65536;

	// Register indexes with no register behind them
	localparam logic [7:0] CFG_UNUSED_LO = 8'd2;
	localparam logic [7:0] CFG_UNUSED_HI = 8'hFF;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 16;
	localparam int RAND_PHASES    = 8;
	localparam int PHASE_ITEMS    = 241;

	typedef struct packed {
		logic [15:0] luma;
		logic [11:0] y;
		logic [11:0] x;
	} pixel_req_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	// s_tdata, low bit up: pixel_x, pixel_y, luma_in
	logic [39:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// m_tdata, low bit up: luma_out
	logic [15:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [13:0] cfg_data  = '0;

	// Local copy of the centre registers
	logic signed [13:0] centre_x = '0;
	logic signed [13:0] centre_y = '0;

	pixel_req_t  pix_q[$];
	logic [15:0] luma_expect_q[$];

	int pix_issued   = 0;
	int pix_accepted = 0;
	int gap_left     = 0;
	int stall_left   = 0;
	int hold_left    = 0;
	int hold_asked   = 0;
	int hold_seen    = 0;
	int quiet_cycles = 0;
	int fail_count   = 0;
	bit send_idle    = 1'b1;
	bit recv_idle    = 1'b1;
	pixel_req_t  drv_req;
	logic [15:0] want_luma;

	radial_spotlight_luma_scale dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Largest r with r*r <= n
	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 20; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	// Scaled luminance for one pixel against the current centre
	function automatic logic [15:0] spot_luma(logic [11:0] px, logic [11:0] py,
			logic [15:0] luma);
		int ax;
		int ay;
		longint unsigned d2;
		longint unsigned scale;
		longint unsigned prod;
		ax = int'(px) - int'(centre_x);
		ay = int'(py) - int'(centre_y);
		if (ax < 0)
			ax = -ax;
		if (ay < 0)
			ay = -ay;
		if (ax > NEAR_LIMIT || ay > NEAR_LIMIT) begin
			scale = DIM_SCALE;
		end else begin
			d2 = ax * ax + ay * ay;
			if (d2 > RADIUS_SQ)
				scale = DIM_SCALE;
			else
				scale = UNITY - ((root_floor(d2 << 16) * SLOPE) >> 15);
		end
		prod = luma * scale;
		return prod[31:16];
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		if (fail_count < 20)
			$display("%0t mismatch: %s, luma_out got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic push_pixel(int x, int y, int luma);
		pixel_req_t req;
		req.x    = x[11:0];
		req.y    = y[11:0];
		req.luma = luma[15:0];
		pix_q.push_back(req);
	endtask

	// Write one register, and follow it in the local copy once taken
	task automatic write_reg(logic [7:0] idx, logic [13:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			rsls_pkg::CFG_CENTER_X: centre_x = val;
			rsls_pkg::CFG_CENTER_Y: centre_y = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold until every queued request has gone in and every result is back
	task automatic wait_drained();
		while (pix_q.size() != 0 || s_tvalid || luma_expect_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Pixels mostly around the centre, the rest anywhere
	task automatic queue_random(int count);
		int x;
		int y;
		int luma;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 7) begin
				x = int'(centre_x) + $urandom_range(340) - 170;
				y = int'(centre_y) + $urandom_range(340) - 170;
				if (x < 0 || x > 4095)
					x = $urandom_range(4095);
				if (y < 0 || y > 4095)
					y = $urandom_range(4095);
			end else begin
				x = $urandom_range(4095);
				y = $urandom_range(4095);
			end
			case ($urandom_range(19))
				0: luma = 0;
				1: luma = 65535;
				default: luma = $urandom_range(65535);
			endcase
			push_pixel(x, y, luma);
		end
	endtask

	task automatic pick_centre();
		int cx;
		int cy;
		if ($urandom_range(9) == 0)
			cx = $urandom_range(16383);
		else
			cx = $urandom_range(4300) - 100;
		if ($urandom_range(9) == 0)
			cy = $urandom_range(16383);
		else
			cy = $urandom_range(4300) - 100;
		write_reg(rsls_pkg::CFG_CENTER_X, cx[13:0]);
		if ($urandom_range(3) == 0)
			write_reg(CFG_UNUSED_LO, 14'($urandom_range(16383)));
		write_reg(rsls_pkg::CFG_CENTER_Y, cy[13:0]);
	endtask

	// Sequence the run: directed checks, random phases, drain and verdict
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Centre at reset value: dead centre, radius edge, far corner
		push_pixel(0, 0, 65535);
		push_pixel(0, 0, 0);
		push_pixel(160, 0, 65535);
		push_pixel(161, 0, 65535);
		push_pixel(113, 113, 40000);
		push_pixel(114, 114, 40000);
		push_pixel(4095, 4095, 65535);
		push_pixel(1, 1, 1);
		wait_drained();

		// Centre inside the frame: exact radius, offset and distance limits
		write_reg(rsls_pkg::CFG_CENTER_X, 14'd200);
		write_reg(rsls_pkg::CFG_CENTER_Y, 14'd200);
		push_pixel(360, 200, 65535);
		push_pixel(361, 200, 65535);
		push_pixel(200, 40, 32768);
		push_pixel(40, 40, 65535);
		push_pixel(313, 313, 65535);
		push_pixel(314, 314, 65535);
		push_pixel(200, 200, 32768);
		wait_drained();

		// Writes to unknown indexes leave the centre alone
		write_reg(CFG_UNUSED_LO, 14'h3FFF);
		write_reg(CFG_UNUSED_HI, 14'h1555);
		push_pixel(200, 200, 65535);
		push_pixel(201, 199, 65535);
		wait_drained();

		// Centre at the register extremes
		write_reg(rsls_pkg::CFG_CENTER_X, 14'h2000);
		write_reg(rsls_pkg::CFG_CENTER_Y, 14'h1FFF);
		push_pixel(0, 0, 65535);
		push_pixel(4095, 4095, 65535);
		wait_drained();
		write_reg(rsls_pkg::CFG_CENTER_X, 14'd4095);
		write_reg(rsls_pkg::CFG_CENTER_Y, 14'h3FFF);
		push_pixel(4095, 0, 65535);
		push_pixel(3935, 0, 65535);
		push_pixel(4000, 50, 12345);
		wait_drained();

		// Random phases; one back-to-back phase with a long output hold-off
		for (int p = 0; p < RAND_PHASES; p++) begin
			pick_centre();
			send_idle = !(p == 1 || p == 3);
			recv_idle = (p != 2);
			if (p == 3)
				hold_asked++;
			queue_random(PHASE_ITEMS);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("radial_spotlight_luma_scale_tb: PASS");
		else
			$display("radial_spotlight_luma_scale_tb: FAIL");
		$finish;
	end

	// Offer the next request once the current one is taken
	always @(negedge clk) begin
		if (!s_tvalid || pix_accepted == pix_issued) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pix_q.size() != 0) begin
				drv_req = pix_q.pop_front();
				s_tdata  <= {drv_req.luma, drv_req.y, drv_req.x};
				s_tvalid <= 1'b1;
				pix_issued++;
				if (send_idle)
					gap_left = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Drive output ready: random stalls, and a long hold-off when asked
	always @(negedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (recv_idle)
				stall_left = pick_gap();
		end
	end

	// Predict on each accepted request, check each result, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				luma_expect_q.push_back(spot_luma(s_tdata[11:0], s_tdata[23:12],
						s_tdata[39:24]));
				pix_accepted++;
			end
			if (m_tvalid && m_tready) begin
				if (luma_expect_q.size() == 0) begin
					report_mismatch("result with no request pending", m_tdata, '0);
				end else begin
					want_luma = luma_expect_q.pop_front();
					if (m_tdata !== want_luma)
						report_mismatch("wrong value", m_tdata, want_luma);
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("radial_spotlight_luma_scale_tb: FAIL");
				$finish;
			end
		end
	end

endmodule

// File: filelist.f
hw/rtl/rsls_pkg.sv
hw/rtl/rsls_offset.sv
hw/rtl/rsls_dist.sv
hw/rtl/rsls_sqrt_stage.sv
hw/rtl/rsls_scale.sv
hw/rtl/radial_spotlight_luma_scale.sv
bench/radial_spotlight_luma_scale_tb.sv
